[hdl/mmq_pkg.sv]
package mmq_pkg;

   localparam int QUEUE_DEPTH_DEF = 1024;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int STATUS_W        = 2;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_POP_LD,
      ST_DONE
   } state_type;

endpackage

[hdl/mmq_if.sv]
interface mmq_req_if #(
   parameter int VALUE_WIDTH = mmq_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [VALUE_WIDTH-1:0] data_value;

   modport source (output valid, cmd, data_value, input ready);
   modport sink   (input valid, cmd, data_value, output ready);
endinterface

interface mmq_rsp_if #(
   parameter int VALUE_WIDTH = mmq_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(mmq_pkg::QUEUE_DEPTH_DEF + 1)
);
   logic                             valid;
   logic                             ready;
   logic signed [VALUE_WIDTH-1:0]    front_value;
   logic signed [VALUE_WIDTH-1:0]    back_value;
   logic signed [VALUE_WIDTH-1:0]    min_value;
   logic signed [VALUE_WIDTH-1:0]    max_value;
   logic [COUNT_WIDTH-1:0]           entry_count;
   logic                             is_empty;
   logic [mmq_pkg::STATUS_W-1:0]     status;

   modport source (output valid, front_value, back_value, min_value, max_value,
                   entry_count, is_empty, status, input ready);
   modport sink   (input valid, front_value, back_value, min_value, max_value,
                   entry_count, is_empty, status, output ready);
endinterface

[hdl/mmq_ram.sv]
module mmq_ram #(
   parameter int WIDTH = 3 * mmq_pkg::VALUE_WIDTH_DEF,
   parameter int DEPTH = mmq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/min_max_queue.sv]
// First-in first-out queue of signed values that also reports the minimum and
// maximum of what it holds. Each request pushes or pops and returns one
// response with front, back, minimum, maximum, count, an empty flag and a
// status (overflow on a push into a full queue, underflow on a pop from an
// empty one; neither changes the contents). Internally it is two stacks, each
// in its own single-port-read RAM, whose entries carry the value with the
// running minimum and maximum; the tops and bottoms are mirrored in registers.
// A pop from an out stack that holds more than one entry does one RAM read to
// refresh the out-stack top. A pop that finds the out stack empty first moves the whole
// in stack over, one entry per cycle through the RAM read. The next request is taken
// while a response still waits in the output register.
module min_max_queue #(
   parameter int QUEUE_DEPTH = mmq_pkg::QUEUE_DEPTH_DEF,
   parameter int VALUE_WIDTH = mmq_pkg::VALUE_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mmq_req_if.sink   req_chan,
   mmq_rsp_if.source rsp_chan
);
   import mmq_pkg::*;

   localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = 3 * VALUE_WIDTH;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] v;
      logic signed [VALUE_WIDTH-1:0] mn;
      logic signed [VALUE_WIDTH-1:0] mx;
   } entry_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              in_depth_ff, in_depth_in;
   logic [CNT_W-1:0]              out_depth_ff, out_depth_in;
   entry_type                     in_top_ff, in_top_in;
   entry_type                     out_top_ff, out_top_in;
   logic signed [VALUE_WIDTH-1:0] in_bot_ff, in_bot_in;
   logic signed [VALUE_WIDTH-1:0] out_bot_ff, out_bot_in;
   logic                          pend_ff, pend_in;
   status_type                    status_ff, status_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_front_ff, rsp_back_ff, rsp_min_ff, rsp_max_ff;
   logic [CNT_W-1:0]              rsp_count_ff;
   logic                          rsp_empty_ff;
   status_type                    rsp_status_ff;

   logic                          req_fire;
   logic                          rsp_load;
   logic [CNT_W-1:0]              count;
   entry_type                     push_entry, move_entry, in_rd_entry;
   logic [ENTRY_W-1:0]            in_rd_data, out_rd_data;
   logic                          in_wr_en, in_rd_en, out_wr_en, out_rd_en;
   logic [ADDR_W-1:0]             in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   logic [ENTRY_W-1:0]            in_wr_data, out_wr_data;
   logic                          pop_go;
   logic signed [VALUE_WIDTH-1:0] sum_front, sum_back, sum_min, sum_max;

   mmq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_in_ram (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_wr_addr),
      .wr_data (in_wr_data),
      .rd_en   (in_rd_en),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   mmq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign count          = in_depth_ff + out_depth_ff;
   assign rsp_load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign in_rd_entry    = entry_type'(in_rd_data);

   // new in-stack entry; ties keep the older running extreme
   always_comb begin
      push_entry.v  = req_chan.data_value;
      push_entry.mn = req_chan.data_value;
      push_entry.mx = req_chan.data_value;
      if (in_depth_ff != '0) begin
         if (!(req_chan.data_value < in_top_ff.mn)) push_entry.mn = in_top_ff.mn;
         if (!(in_top_ff.mx < req_chan.data_value)) push_entry.mx = in_top_ff.mx;
      end
   end

   // entry moved from the in stack onto the out stack
   always_comb begin
      move_entry.v  = in_rd_entry.v;
      move_entry.mn = in_rd_entry.v;
      move_entry.mx = in_rd_entry.v;
      if (out_depth_ff != '0) begin
         if (!(in_rd_entry.v < out_top_ff.mn)) move_entry.mn = out_top_ff.mn;
         if (!(out_top_ff.mx < in_rd_entry.v)) move_entry.mx = out_top_ff.mx;
      end
   end

   // pop from a non-empty out stack; valid in IDLE on transfer or end of MOVE
   assign pop_go = ((state_ff == ST_IDLE) && req_fire && req_chan.cmd == CMD_POP
                    && count != '0 && out_depth_ff != '0)
                || ((state_ff == ST_MOVE) && !pend_ff && in_depth_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.cmd == CMD_POP && count != '0 && out_depth_ff == '0) begin
                  state_in = ST_MOVE;
               end else if (pop_go && out_depth_ff >= CNT_W'(2)) begin
                  state_in = ST_POP_LD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOVE: begin
            if (pop_go) begin
               state_in = (out_depth_ff >= CNT_W'(2)) ? ST_POP_LD : ST_DONE;
            end
         end
         ST_POP_LD: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      in_depth_in  = in_depth_ff;
      out_depth_in = out_depth_ff;
      in_top_in    = in_top_ff;
      out_top_in   = out_top_ff;
      in_bot_in    = in_bot_ff;
      out_bot_in   = out_bot_ff;
      pend_in      = 1'b0;
      status_in    = status_ff;
      in_wr_en     = 1'b0;
      in_wr_addr   = in_depth_ff[ADDR_W-1:0];
      in_wr_data   = push_entry;
      in_rd_en     = 1'b0;
      in_rd_addr   = ADDR_W'(in_depth_ff - CNT_W'(1));
      out_wr_en    = 1'b0;
      out_wr_addr  = out_depth_ff[ADDR_W-1:0];
      out_wr_data  = move_entry;
      out_rd_en    = 1'b0;
      out_rd_addr  = ADDR_W'(out_depth_ff - CNT_W'(2));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_OK;
               if (req_chan.cmd == CMD_PUSH) begin
                  if (count == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     in_wr_en    = 1'b1;
                     in_top_in   = push_entry;
                     in_depth_in = in_depth_ff + CNT_W'(1);
                     if (in_depth_ff == '0) in_bot_in = req_chan.data_value;
                  end
               end else if (count == '0) begin
                  status_in = STATUS_UNDERFLOW;
               end
            end
         end
         ST_MOVE: begin
            // read in-stack top-down; each entry lands in the cycle after its read
            if (pend_ff) begin
               out_wr_en    = 1'b1;
               out_top_in   = move_entry;
               out_depth_in = out_depth_ff + CNT_W'(1);
               if (out_depth_ff == '0) out_bot_in = in_rd_entry.v;
            end
            if (in_depth_ff != '0) begin
               in_rd_en    = 1'b1;
               in_depth_in = in_depth_ff - CNT_W'(1);
               pend_in     = 1'b1;
            end
         end
         ST_POP_LD: out_top_in = entry_type'(out_rd_data);
         ST_DONE: ;
         default: ;
      endcase

      if (pop_go) begin
         out_depth_in = out_depth_ff - CNT_W'(1);
         out_rd_en    = (out_depth_ff >= CNT_W'(2));
      end
   end

   // response summary from the mirrored tops and bottoms
   always_comb begin
      sum_front = (out_depth_ff == '0) ? in_bot_ff : out_top_ff.v;
      sum_back  = (in_depth_ff != '0) ? in_top_ff.v : out_bot_ff;
      if (in_depth_ff == '0) begin
         sum_min = out_top_ff.mn;
         sum_max = out_top_ff.mx;
      end else if (out_depth_ff == '0) begin
         sum_min = in_top_ff.mn;
         sum_max = in_top_ff.mx;
      end else begin
         sum_min = (in_top_ff.mn < out_top_ff.mn) ? in_top_ff.mn : out_top_ff.mn;
         sum_max = (in_top_ff.mx < out_top_ff.mx) ? out_top_ff.mx : in_top_ff.mx;
      end
      if (count == '0) begin
         sum_front = '0;
         sum_back  = '0;
         sum_min   = '0;
         sum_max   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_depth_ff  <= '0;
         out_depth_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_depth_ff  <= in_depth_in;
         out_depth_ff <= out_depth_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_top_ff  <= in_top_in;
      out_top_ff <= out_top_in;
      in_bot_ff  <= in_bot_in;
      out_bot_ff <= out_bot_in;
      status_ff  <= status_in;
      if (rsp_load) begin
         rsp_front_ff  <= sum_front;
         rsp_back_ff   <= sum_back;
         rsp_min_ff    <= sum_min;
         rsp_max_ff    <= sum_max;
         rsp_count_ff  <= count;
         rsp_empty_ff  <= (count == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.back_value  = rsp_back_ff;
   assign rsp_chan.min_value   = rsp_min_ff;
   assign rsp_chan.max_value   = rsp_max_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.status      = rsp_status_ff;
endmodule

[verif/testbench.sv]
module testbench;
   import mmq_pkg::*;

   localparam int DEPTH      = QUEUE_DEPTH_DEF;
   localparam int IN_STK     = 0;
   localparam int OUT_STK    = 1;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 50;

   typedef struct {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic [10:0]        entry_count;
      logic               is_empty;
      status_type         status;
   } queue_report_type;

   logic clock = 1'b0;
   logic reset;

   mmq_req_if req_chan ();
   mmq_rsp_if rsp_chan ();

   min_max_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // shadow copy of both stacks
   logic signed [31:0] stk_val [2][DEPTH];
   logic signed [31:0] stk_min [2][DEPTH];
   logic signed [31:0] stk_max [2][DEPTH];
   int                 stk_cnt [2];

   queue_report_type expected_reports [$];
   int          error_count   = 0;
   int          cycle_count   = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   function automatic void stack_push(int s, logic signed [31:0] v);
      int d;
      d = stk_cnt[s];
      stk_val[s][d] = v;
      stk_min[s][d] = v;
      stk_max[s][d] = v;
      if (d > 0) begin
         if (!(v < stk_min[s][d-1])) stk_min[s][d] = stk_min[s][d-1];
         if (!(stk_max[s][d-1] < v)) stk_max[s][d] = stk_max[s][d-1];
      end
      stk_cnt[s] = d + 1;
   endfunction

   function automatic int held_count();
      return stk_cnt[IN_STK] + stk_cnt[OUT_STK];
   endfunction

   function automatic queue_report_type apply_queue_op(cmd_type op, logic signed [31:0] v);
      queue_report_type r;
      int ni;
      int no;
      r.status = STATUS_OK;
      if (op == CMD_PUSH) begin
         if (held_count() >= DEPTH) r.status = STATUS_OVERFLOW;
         else stack_push(IN_STK, v);
      end else if (held_count() == 0) begin
         r.status = STATUS_UNDERFLOW;
      end else begin
         if (stk_cnt[OUT_STK] == 0) begin
            while (stk_cnt[IN_STK] > 0) begin
               stk_cnt[IN_STK]--;
               stack_push(OUT_STK, stk_val[IN_STK][stk_cnt[IN_STK]]);
            end
         end
         stk_cnt[OUT_STK]--;
      end
      ni = stk_cnt[IN_STK];
      no = stk_cnt[OUT_STK];
      r.front_value = '0;
      r.back_value  = '0;
      r.min_value   = '0;
      r.max_value   = '0;
      if (ni + no > 0) begin
         r.front_value = (no == 0) ? stk_val[IN_STK][0] : stk_val[OUT_STK][no-1];
         r.back_value  = (ni > 0) ? stk_val[IN_STK][ni-1] : stk_val[OUT_STK][0];
         if (ni == 0) begin
            r.min_value = stk_min[OUT_STK][no-1];
            r.max_value = stk_max[OUT_STK][no-1];
         end else if (no == 0) begin
            r.min_value = stk_min[IN_STK][ni-1];
            r.max_value = stk_max[IN_STK][ni-1];
         end else begin
            r.min_value = (stk_min[IN_STK][ni-1] < stk_min[OUT_STK][no-1]) ?
                          stk_min[IN_STK][ni-1] : stk_min[OUT_STK][no-1];
            r.max_value = (stk_max[IN_STK][ni-1] < stk_max[OUT_STK][no-1]) ?
                          stk_max[OUT_STK][no-1] : stk_max[IN_STK][ni-1];
         end
      end
      r.entry_count = 11'(ni + no);
      r.is_empty    = (ni + no == 0);
      return r;
   endfunction

   // half full-range values, the rest extremes or a narrow band to force ties
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3, 4: return $signed($urandom_range(7)) - 4;
         default: return $urandom();
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_cmd(cmd_type op, logic signed [31:0] v);
      queue_report_type rpt;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= op;
      req_chan.data_value <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      rpt = apply_queue_op(op, v);
      expected_reports.insert(expected_reports.size(), rpt);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_report_type e;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual count %0d",
                     $time, rsp_chan.entry_count);
            error_count++;
         end else begin
            e = expected_reports.pop_front();
            check_field("front_value", e.front_value, rsp_chan.front_value);
            check_field("back_value", e.back_value, rsp_chan.back_value);
            check_field("min_value", e.min_value, rsp_chan.min_value);
            check_field("max_value", e.max_value, rsp_chan.max_value);
            check_field("entry_count", 32'(e.entry_count), 32'(rsp_chan.entry_count));
            check_field("is_empty", 32'(e.is_empty), 32'(rsp_chan.is_empty));
            check_field("status", 32'(e.status), 32'(rsp_chan.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed();
      send_cmd(CMD_POP, 0);                 // underflow on empty
      send_cmd(CMD_PUSH, 5);
      send_cmd(CMD_PUSH, 5);                // tie with running min and max
      send_cmd(CMD_PUSH, 32'sh7FFF_FFFF);
      send_cmd(CMD_PUSH, 32'sh8000_0000);
      send_cmd(CMD_PUSH, 0);
      send_cmd(CMD_PUSH, -1);
      send_cmd(CMD_POP, 0);                 // moves six entries
      send_cmd(CMD_PUSH, 32'sh5555_5555);   // both stacks in use
      send_cmd(CMD_PUSH, 32'shAAAA_AAAA);
      repeat (5) send_cmd(CMD_POP, 0);
      send_cmd(CMD_POP, 0);                 // second move
      send_cmd(CMD_POP, 0);
      send_cmd(CMD_POP, 32'shFFFF_FFFF);    // underflow, data ignored
      send_cmd(CMD_PUSH, -7);
      send_cmd(CMD_POP, 0);
   endtask

   task automatic test_random_mix(int items);
      int cap;
      int push_pct;
      cap = $urandom_range(40, 4);
      repeat (items) begin
         if (held_count() == 0) push_pct = 80;
         else if (held_count() >= cap) push_pct = 30;
         else push_pct = 55;
         if ($urandom_range(99) < push_pct) send_cmd(CMD_PUSH, pick_value());
         else send_cmd(CMD_POP, $urandom());
         if ($urandom_range(19) == 0) cap = $urandom_range(40, 4);
      end
   endtask

   task automatic test_fill_overflow();
      while (held_count() < DEPTH) send_cmd(CMD_PUSH, pick_value());
      repeat (3) send_cmd(CMD_PUSH, pick_value());
      send_cmd(CMD_POP, 0);                 // pop from a full queue
      send_cmd(CMD_PUSH, pick_value());
      send_cmd(CMD_PUSH, pick_value());     // full with both stacks in use
      repeat (60) begin
         if ($urandom_range(1)) send_cmd(CMD_PUSH, pick_value());
         else send_cmd(CMD_POP, 0);
      end
      repeat (20) send_cmd(CMD_POP, 0);
   endtask

   task automatic set_idle(int snd, int rcv);
      send_idle_pct  = snd;
      recv_stall_pct = rcv;
   endtask

   initial begin
      stk_cnt[IN_STK]     = 0;
      stk_cnt[OUT_STK]    = 0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_PUSH;
      req_chan.data_value = '0;
      rsp_chan.ready      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idle(0, 0);
      test_directed();
      set_idle(77, 0);
      test_directed();
      set_idle(0, 0);
      test_random_mix(50);
      set_idle(77, 0);
      test_random_mix(50);
      set_idle(0, 77);
      test_random_mix(50);
      set_idle(18, 18);
      test_random_mix(50);
      test_fill_overflow();

      req_chan.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[min_max_queue.f]
hdl/mmq_pkg.sv
hdl/mmq_if.sv
hdl/mmq_ram.sv
hdl/min_max_queue.sv
verif/testbench.sv
